@@ hdl/pbdl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pbdl_pkg;

   localparam int SLOTS  = 32;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int PAGE_W = 60;

   typedef logic [3:0] cmd_type;
   localparam cmd_type CMD_FETCH      = 4'd0;
   localparam cmd_type CMD_PIN        = 4'd1;
   localparam cmd_type CMD_UNPIN      = 4'd2;
   localparam cmd_type CMD_DIRTY      = 4'd3;
   localparam cmd_type CMD_FREE       = 4'd4;
   localparam cmd_type CMD_FLUSH      = 4'd5;
   localparam cmd_type CMD_FLUSH_EVICT = 4'd6;
   localparam cmd_type CMD_FLUSH_FILE = 4'd7;
   localparam cmd_type CMD_FLUSH_ALL  = 4'd8;
   localparam cmd_type CMD_PURGE      = 4'd9;

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_HIT   = 3'd0;
   localparam kind_type KIND_LOAD  = 3'd1;
   localparam kind_type KIND_WB    = 3'd2;
   localparam kind_type KIND_FREE  = 3'd3;
   localparam kind_type KIND_DONE  = 3'd4;
   localparam kind_type KIND_ERROR = 3'd5;

   typedef logic [3:0] op_type;
   localparam op_type OP_NONE       = 4'd0;
   localparam op_type OP_LATCH      = 4'd1;
   localparam op_type OP_LOOKUP     = 4'd2;
   localparam op_type OP_HIT        = 4'd3;
   localparam op_type OP_LOAD       = 4'd4;
   localparam op_type OP_SCAN_INIT  = 4'd5;
   localparam op_type OP_SCAN_STEP  = 4'd6;
   localparam op_type OP_EVICT      = 4'd7;
   localparam op_type OP_ERROR      = 4'd8;
   localparam op_type OP_FLAG       = 4'd9;
   localparam op_type OP_FREE       = 4'd10;
   localparam op_type OP_FLUSH      = 4'd11;
   localparam op_type OP_FLUSH_STEP = 4'd12;
   localparam op_type OP_PURGE      = 4'd13;
   localparam op_type OP_DONE0      = 4'd14;

   typedef struct packed {
      logic [3:0]        command;
      logic [3:0]        file_number;
      logic [PAGE_W-1:0] page_number;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [3:0]        out_file;
      logic [PAGE_W-1:0] out_page;
      logic [4:0]        slot;
      logic              last;
   } rsp_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      cmd_type command;
      logic    hit;
      logic    full;
      logic    victim_found;
      logic    scan_last;
      logic    mask_any;
      logic    mask_last;
   } sts_type;

endpackage
`default_nettype wire

@@ hdl/pbdl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pbdl_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  pbdl_pkg::sts_type  sts,
   output pbdl_pkg::ctl_type  ctl
);
   import pbdl_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOKUP = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_EVICT  = 3'd4;
   localparam logic [2:0] ST_LOAD   = 3'd5;
   localparam logic [2:0] ST_FLUSH  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.op   = OP_LATCH;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ctl.op   = OP_LOOKUP;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            case (sts.command)
               CMD_FETCH: begin
                  if (sts.hit) ctl.op = OP_HIT;
                  else if (!sts.full) ctl.op = OP_LOAD;
                  else begin
                     ctl.op   = OP_SCAN_INIT;
                     state_in = ST_SCAN;
                  end
               end
               CMD_PIN, CMD_UNPIN, CMD_DIRTY: ctl.op = OP_FLAG;
               CMD_FREE:                      ctl.op = OP_FREE;
               CMD_FLUSH, CMD_FLUSH_EVICT:    ctl.op = OP_FLUSH;
               CMD_FLUSH_FILE, CMD_FLUSH_ALL: begin
                  if (sts.mask_any) state_in = ST_FLUSH;
                  else ctl.op = OP_DONE0;
               end
               CMD_PURGE: ctl.op = OP_PURGE;
               default:   ctl.op = OP_DONE0;
            endcase
         end
         ST_SCAN: begin
            ctl.op = OP_SCAN_STEP;
            if (sts.scan_last) state_in = ST_EVICT;
         end
         ST_EVICT: begin
            if (sts.victim_found) begin
               ctl.op   = OP_EVICT;
               state_in = ST_LOAD;
            end else begin
               ctl.op   = OP_ERROR;
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            ctl.op   = OP_LOAD;
            state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            ctl.op = OP_FLUSH_STEP;
            if (sts.mask_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

@@ hdl/pbdl_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pbdl_dp (
   input  wire                clock,
   input  wire                reset,
   input  pbdl_pkg::req_type  req,
   input  pbdl_pkg::ctl_type  ctl,
   output pbdl_pkg::sts_type  sts,
   output logic               rsp_valid,
   output pbdl_pkg::rsp_type  rsp
);
   import pbdl_pkg::*;

   req_type             req_ff, req_in;
   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic [SLOTS-1:0]    dirty_ff, dirty_in;
   logic [SLOTS-1:0]    pinned_ff, pinned_in;
   logic [3:0]          file_ff [SLOTS];
   logic [3:0]          file_in [SLOTS];
   logic [PAGE_W-1:0]   page_ff [SLOTS];
   logic [PAGE_W-1:0]   page_in [SLOTS];
   logic [IDX_W-1:0]    rank_ff [SLOTS];
   logic [IDX_W-1:0]    rank_in [SLOTS];

   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                full_ff, full_in;
   logic [SLOTS-1:0]    mask_ff, mask_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [CNT_W-1:0]    count;
   logic                look_hit;
   logic [IDX_W-1:0]    look_idx;
   logic [IDX_W-1:0]    free_idx;
   logic [IDX_W-1:0]    mask_idx;
   logic [SLOTS-1:0]    mask_rest;
   logic                do_dec;
   logic [IDX_W-1:0]    dec_idx;

   always_comb begin
      count    = '0;
      look_hit = 1'b0;
      look_idx = '0;
      free_idx = '0;
      mask_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         count = count + CNT_W'(valid_ff[i]);
         if (valid_ff[i] && file_ff[i] == req_ff.file_number &&
             page_ff[i] == req_ff.page_number) begin
            look_hit = 1'b1;
            look_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) free_idx = IDX_W'(i);
         if (mask_ff[i]) mask_idx = IDX_W'(i);
      end
      mask_rest = mask_ff & ~(SLOTS'(1) << mask_idx);
   end

   assign sts.command      = req_ff.command;
   assign sts.hit          = hit_ff;
   assign sts.full         = full_ff;
   assign sts.victim_found = found_ff;
   assign sts.scan_last    = (scan_ff == IDX_W'(SLOTS - 1));
   assign sts.mask_any     = |mask_ff;
   assign sts.mask_last    = ~|mask_rest;

   always_comb begin
      req_in       = req_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      pinned_in    = pinned_ff;
      file_in      = file_ff;
      page_in      = page_ff;
      rank_in      = rank_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      full_in      = full_ff;
      mask_in      = mask_ff;
      scan_in      = scan_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      do_dec       = 1'b0;
      dec_idx      = hit_idx_ff;

      // default beat: done for the request page, slot 0, last
      rsp_in.kind     = KIND_DONE;
      rsp_in.out_file = req_ff.file_number;
      rsp_in.out_page = req_ff.page_number;
      rsp_in.slot     = '0;
      rsp_in.last     = 1'b1;

      case (ctl.op)
         OP_LATCH: req_in = req;
         OP_LOOKUP: begin
            hit_in     = look_hit;
            hit_idx_in = look_idx;
            full_in    = (count >= CNT_W'(SLOTS));
            for (int i = 0; i < SLOTS; i++)
               mask_in[i] = valid_ff[i] && dirty_ff[i] &&
                  (req_ff.command == CMD_FLUSH_ALL || file_ff[i] == req_ff.file_number);
         end
         OP_HIT: begin
            do_dec              = 1'b1;
            rank_in[hit_idx_ff] = IDX_W'(count - CNT_W'(1));
            rsp_valid_in        = 1'b1;
            rsp_in.kind         = KIND_HIT;
            rsp_in.slot         = 5'(hit_idx_ff);
         end
         OP_LOAD: begin
            rank_in[free_idx]   = IDX_W'(count);
            valid_in[free_idx]  = 1'b1;
            dirty_in[free_idx]  = 1'b0;
            pinned_in[free_idx] = 1'b0;
            file_in[free_idx]   = req_ff.file_number;
            page_in[free_idx]   = req_ff.page_number;
            rsp_valid_in        = 1'b1;
            rsp_in.kind         = KIND_LOAD;
            rsp_in.slot         = 5'(free_idx);
         end
         OP_SCAN_INIT: begin
            scan_in  = '0;
            found_in = 1'b0;
         end
         OP_SCAN_STEP: begin
            if (valid_ff[scan_ff] && !pinned_ff[scan_ff] &&
                (!found_ff || rank_ff[scan_ff] < rank_ff[best_ff])) begin
               best_in  = scan_ff;
               found_in = 1'b1;
            end
            scan_in = scan_ff + IDX_W'(1);
         end
         OP_EVICT: begin
            do_dec            = 1'b1;
            dec_idx           = best_ff;
            valid_in[best_ff] = 1'b0;
            dirty_in[best_ff] = 1'b0;
            pinned_in[best_ff] = 1'b0;
            rsp_valid_in      = dirty_ff[best_ff];
            rsp_in.kind       = KIND_WB;
            rsp_in.out_file   = file_ff[best_ff];
            rsp_in.out_page   = page_ff[best_ff];
            rsp_in.slot       = 5'(best_ff);
            rsp_in.last       = 1'b0;
         end
         OP_ERROR: begin
            rsp_valid_in = 1'b1;
            rsp_in.kind  = KIND_ERROR;
         end
         OP_FLAG: begin
            rsp_valid_in = 1'b1;
            if (hit_ff) begin
               rsp_in.slot = 5'(hit_idx_ff);
               if (req_ff.command == CMD_PIN) pinned_in[hit_idx_ff] = 1'b1;
               else if (req_ff.command == CMD_UNPIN) pinned_in[hit_idx_ff] = 1'b0;
               else dirty_in[hit_idx_ff] = 1'b1;
            end
         end
         OP_FREE: begin
            rsp_valid_in = 1'b1;
            if (hit_ff) begin
               do_dec                = 1'b1;
               valid_in[hit_idx_ff]  = 1'b0;
               dirty_in[hit_idx_ff]  = 1'b0;
               pinned_in[hit_idx_ff] = 1'b0;
               rsp_in.kind           = KIND_FREE;
               rsp_in.slot           = 5'(hit_idx_ff);
            end
         end
         OP_FLUSH: begin
            rsp_valid_in = 1'b1;
            if (hit_ff) begin
               rsp_in.slot = 5'(hit_idx_ff);
               if (dirty_ff[hit_idx_ff]) begin
                  dirty_in[hit_idx_ff] = 1'b0;
                  rsp_in.kind          = KIND_WB;
               end
               if (req_ff.command == CMD_FLUSH_EVICT) begin
                  do_dec                = 1'b1;
                  valid_in[hit_idx_ff]  = 1'b0;
                  dirty_in[hit_idx_ff]  = 1'b0;
                  pinned_in[hit_idx_ff] = 1'b0;
               end
            end
         end
         OP_FLUSH_STEP: begin
            dirty_in[mask_idx] = 1'b0;
            mask_in            = mask_rest;
            rsp_valid_in       = 1'b1;
            rsp_in.kind        = KIND_WB;
            rsp_in.out_file    = file_ff[mask_idx];
            rsp_in.out_page    = page_ff[mask_idx];
            rsp_in.slot        = 5'(mask_idx);
            rsp_in.last        = ~|mask_rest;
         end
         OP_PURGE: begin
            valid_in     = '0;
            dirty_in     = '0;
            pinned_in    = '0;
            rsp_valid_in = 1'b1;
         end
         OP_DONE0: rsp_valid_in = 1'b1;
         default: ;
      endcase

      // close the rank gap left by the entry that moves or leaves
      if (do_dec) begin
         for (int i = 0; i < SLOTS; i++)
            if (IDX_W'(i) != dec_idx && valid_ff[i] && rank_ff[i] > rank_ff[dec_idx])
               rank_in[i] = rank_ff[i] - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         pinned_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         pinned_ff    <= pinned_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      file_ff    <= file_in;
      page_ff    <= page_in;
      rank_ff    <= rank_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      full_ff    <= full_in;
      mask_ff    <= mask_in;
      scan_ff    <= scan_in;
      best_ff    <= best_in;
      found_ff   <= found_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

@@ hdl/page_buffer_directory_lru.sv @@
// A request passes the lookup and decide states. Fetch hits, loads into a free slot, flag,
// free, flush, purge and unused commands beat from decide; flush file / flush all go on to the
// flush state, one write-back beat per dirty page, or beat done from decide if none is dirty.
// A fetch miss on a full pool walks the 32 recency ranks one slot per cycle, then gives a
// write-back beat if the victim is dirty and a load beat, or an error beat if all are pinned.
// One request at a time; busy drops with the last beat. No result stall. Reset frees every slot.
`timescale 1ns / 1ps
`default_nettype none
module page_buffer_directory_lru (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  pbdl_pkg::req_type  req,
   output logic               rsp_valid,
   output pbdl_pkg::rsp_type  rsp
);
   import pbdl_pkg::*;

   ctl_type ctl;
   sts_type sts;

   pbdl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   pbdl_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire
